[sv/mrt_pkg.sv]
// ---------------------------------------------------------------------------
// mrt_pkg: shared constants and helpers for the Modbus register responder
// Command codes, table geometry, frame constants and the CRC-16 byte step.
// ---------------------------------------------------------------------------
package mrt_pkg;

   // table geometry
   localparam int TABLE_DEPTH    = 4096;
   localparam int TBL_AW         = $clog2(TABLE_DEPTH);
   localparam int MAX_READ_WORDS = 125;
   localparam int WORD_CW        = $clog2(MAX_READ_WORDS + 1);

   // request commands
   localparam logic [2:0] CMD_READ     = 3'd0;
   localparam logic [2:0] CMD_WR_ONE   = 3'd1;
   localparam logic [2:0] CMD_WR_HDR   = 3'd2;
   localparam logic [2:0] CMD_WR_DATA  = 3'd3;
   localparam logic [2:0] CMD_PRELOAD  = 3'd4;

   // configuration register indexes
   localparam logic CSR_TABLE_END = 1'b0;
   localparam logic CSR_STD_MODE  = 1'b1;

   // exception frame
   localparam logic [7:0] EXC_FUNC      = 8'h80;
   localparam logic [7:0] EXC_ADDRESS   = 8'h00;
   localparam logic [7:0] EXC_VALUE     = 8'h01;

   // CRC-16/MODBUS
   localparam logic [15:0] CRC_INIT = 16'hffff;
   localparam logic [15:0] CRC_POLY = 16'ha001;

   // header lengths
   localparam logic [2:0] HDR_SHORT = 3'd3;
   localparam logic [2:0] HDR_LONG  = 3'd6;

   typedef logic [7:0] byte_type;

   // fold one byte into the reflected CRC
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input byte_type b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int n = 0; n < 8; n++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[sv/mrt_ram.sv]
// ---------------------------------------------------------------------------
// mrt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without re.
// ---------------------------------------------------------------------------
module mrt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

[sv/modbus_register_table_responder.sv]
// ---------------------------------------------------------------------------
// modbus_register_table_responder: Modbus holding-register slave table
// Serves reads, single and multiple writes and preloads against a word table,
// building response frames with CRC-16 and packing them four bytes a group.
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req_    | in        | req_valid/req_ready  | cmd, unit, func, address, count, ...
//  rsp_    | out       | rsp_valid/rsp_ready  | byte0..byte3, nbytes, last
//  csr_    | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
//  A request is taken only in idle. A read sends the header, then each word
//  as one table read and its high and low byte through the byte/CRC unit,
//  then the CRC. Exceptions and echoed writes send a header and the CRC.
//  After reset the table is cleared, one entry a cycle, with req_ready low
//  until the pass ends. A stalled rsp_ready holds the byte sequencer.
// ---------------------------------------------------------------------------
module modbus_register_table_responder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [7:0]  req_unit_byte,
   input  logic [7:0]  req_func_byte,
   input  logic [15:0] req_address,
   input  logic [15:0] req_count,
   input  logic [7:0]  req_byte_count,
   input  logic [15:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_byte0,
   output logic [7:0]  rsp_byte1,
   output logic [7:0]  rsp_byte2,
   output logic [7:0]  rsp_byte3,
   output logic [2:0]  rsp_nbytes,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [11:0] csr_wdata
);

   localparam int AW = mrt_pkg::TBL_AW;
   localparam int WC = mrt_pkg::WORD_CW;
   localparam logic [16:0] DEPTH17 = 17'(mrt_pkg::TABLE_DEPTH);
   localparam logic [15:0] MAXW16  = 16'(mrt_pkg::MAX_READ_WORDS);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_HDR   = 3'd2;
   localparam logic [2:0] S_RADDR = 3'd3;
   localparam logic [2:0] S_RHI   = 3'd4;
   localparam logic [2:0] S_RLO   = 3'd5;
   localparam logic [2:0] S_CRC0  = 3'd6;
   localparam logic [2:0] S_CRC1  = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [11:0] tend_ff, tend_in;
   logic        std_ff, std_in;
   logic        wa_ff, wa_in;
   logic [15:0] wp_ff, wp_in;
   logic [15:0] wr_ff, wr_in;
   logic [47:0] echo_ff, echo_in;
   logic [7:0]  hdr_ff [6];
   logic [7:0]  hdr_in [6];
   logic [2:0]  hlen_ff, hlen_in;
   logic [2:0]  hidx_ff, hidx_in;
   logic [WC-1:0] words_ff, words_in;
   logic [16:0] raddr_ff, raddr_in;
   logic        oor_ff, oor_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  acc_ff [3];
   logic [7:0]  acc_in [3];
   logic [1:0]  acnt_ff, acnt_in;
   logic        rv_ff, rv_in;
   logic [7:0]  rb_ff [4];
   logic [7:0]  rb_in [4];
   logic [2:0]  rn_ff, rn_in;
   logic        rl_ff, rl_in;

   logic        accept, out_free, emit, elast;
   logic [7:0]  ebyte;
   logic        ram_we, ram_re;
   logic [AW-1:0] ram_wa;
   logic [15:0] ram_wd, ram_rd;
   logic [16:0] end1, sum, a17, ap1;
   logic [16:0] widx;
   logic        wen;

   mrt_ram #(.WIDTH(16), .DEPTH(mrt_pkg::TABLE_DEPTH)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_wa),
      .wdata (ram_wd),
      .re    (ram_re),
      .raddr (raddr_ff[AW-1:0]),
      .rdata (ram_rd)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign out_free  = !rv_ff || rsp_ready;

   assign end1 = {5'd0, tend_ff} + 17'd1;
   assign a17  = {1'b0, req_address};
   assign sum  = a17 + {1'b0, req_count};
   assign ap1  = a17 + 17'd1;

   // select the byte the sequencer offers this cycle
   always_comb begin
      emit  = 1'b0;
      elast = 1'b0;
      ebyte = 8'h00;
      unique case (state_ff)
         S_HDR: begin
            emit  = out_free;
            ebyte = hdr_ff[hidx_ff];
         end
         S_RHI: begin
            emit  = out_free;
            ebyte = oor_ff ? 8'h00 : ram_rd[15:8];
         end
         S_RLO: begin
            emit  = out_free;
            ebyte = oor_ff ? 8'h00 : ram_rd[7:0];
         end
         S_CRC0: begin
            emit  = out_free;
            ebyte = crc_ff[7:0];
         end
         S_CRC1: begin
            emit  = out_free;
            ebyte = crc_ff[15:8];
            elast = 1'b1;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // configuration writes, sequencer, request decode and table writes
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      tend_in  = tend_ff;
      std_in   = std_ff;
      wa_in    = wa_ff;
      wp_in    = wp_ff;
      wr_in    = wr_ff;
      echo_in  = echo_ff;
      hdr_in   = hdr_ff;
      hlen_in  = hlen_ff;
      hidx_in  = hidx_ff;
      words_in = words_ff;
      raddr_in = raddr_ff;
      oor_in   = oor_ff;
      crc_in   = crc_ff;
      ram_re   = 1'b0;
      wen      = 1'b0;
      widx     = a17;

      // configuration writes
      if (csr_valid && csr_ready) begin
         if (csr_index == mrt_pkg::CSR_TABLE_END) begin
            tend_in = csr_wdata;
         end else begin
            std_in = csr_wdata[0];
         end
      end

      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               crc_in   = mrt_pkg::CRC_INIT;
               hidx_in  = 3'd0;
               words_in = '0;
               hdr_in[0] = req_unit_byte;
               hdr_in[1] = mrt_pkg::EXC_FUNC;
               hdr_in[2] = mrt_pkg::EXC_ADDRESS;
               hdr_in[3] = req_address[15:8];
               hdr_in[4] = req_address[7:0];
               hdr_in[5] = req_value[7:0];
               hlen_in   = mrt_pkg::HDR_SHORT;
               case (req_cmd)
                  mrt_pkg::CMD_READ: begin
                     state_in = S_HDR;
                     if (sum > end1) begin
                        hdr_in[2] = mrt_pkg::EXC_ADDRESS;
                     end else if (std_ff && (req_count == 16'd0 || req_count > MAXW16)) begin
                        hdr_in[2] = mrt_pkg::EXC_VALUE;
                     end else begin
                        hdr_in[1] = req_func_byte;
                        hdr_in[2] = std_ff ? {req_count[6:0], 1'b0} : 8'h00;
                        words_in  = (req_count > MAXW16) ? WC'(mrt_pkg::MAX_READ_WORDS)
                                                          : req_count[WC-1:0];
                        raddr_in  = std_ff ? ap1 : a17;
                     end
                  end
                  mrt_pkg::CMD_WR_ONE: begin
                     state_in = S_HDR;
                     if (a17 > end1) begin
                        hdr_in[2] = mrt_pkg::EXC_ADDRESS;
                     end else begin
                        wen       = (ap1 < DEPTH17);
                        widx      = ap1;
                        hdr_in[1] = req_func_byte;
                        hdr_in[2] = req_address[15:8];
                        hdr_in[3] = req_address[7:0];
                        hdr_in[4] = req_value[15:8];
                        hlen_in   = mrt_pkg::HDR_LONG;
                     end
                  end
                  mrt_pkg::CMD_WR_HDR: begin
                     wa_in = 1'b0;
                     if (sum > end1) begin
                        state_in = S_HDR;
                     end else if (std_ff && (req_count == 16'd0 || req_count > MAXW16 ||
                                  {9'd0, req_byte_count} != {req_count, 1'b0})) begin
                        state_in  = S_HDR;
                        hdr_in[2] = mrt_pkg::EXC_VALUE;
                     end else if (req_count != 16'd0) begin
                        wa_in   = 1'b1;
                        wp_in   = req_address + 16'd1;
                        wr_in   = req_count;
                        echo_in = {req_unit_byte, req_func_byte, req_address, req_count};
                     end
                  end
                  mrt_pkg::CMD_WR_DATA: begin
                     if (wa_ff) begin
                        wen   = ({1'b0, wp_ff} < DEPTH17);
                        widx  = {1'b0, wp_ff};
                        wp_in = wp_ff + 16'd1;
                        wr_in = wr_ff - 16'd1;
                        if (wr_ff == 16'd1) begin
                           wa_in    = 1'b0;
                           state_in = S_HDR;
                           for (int i = 0; i < 6; i++) begin
                              hdr_in[i] = echo_ff[47-8*i -: 8];
                           end
                           hlen_in = mrt_pkg::HDR_LONG;
                        end
                     end
                  end
                  mrt_pkg::CMD_PRELOAD: begin
                     wen  = (a17 < DEPTH17);
                     widx = a17;
                  end
                  default: begin
                     wen = 1'b0;
                  end
               endcase
            end
         end
         S_HDR: begin
            if (emit) begin
               hidx_in = hidx_ff + 3'd1;
               if (hidx_ff == hlen_ff - 3'd1) begin
                  state_in = (words_ff != '0) ? S_RADDR : S_CRC0;
               end
            end
         end
         S_RADDR: begin
            ram_re   = 1'b1;
            oor_in   = (raddr_ff >= DEPTH17);
            state_in = S_RHI;
         end
         S_RHI: begin
            if (emit) begin
               state_in = S_RLO;
            end
         end
         S_RLO: begin
            if (emit) begin
               words_in = words_ff - 1'b1;
               raddr_in = raddr_ff + 17'd1;
               state_in = (words_ff == WC'(1)) ? S_CRC0 : S_RADDR;
            end
         end
         S_CRC0: begin
            if (emit) begin
               state_in = S_CRC1;
            end
         end
         S_CRC1: begin
            if (emit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // fold frame bytes into the CRC, not the CRC bytes themselves
      if (emit && state_ff != S_CRC0 && state_ff != S_CRC1) begin
         crc_in = mrt_pkg::crc_byte(crc_ff, ebyte);
      end
   end

   // table write port: clearing pass or request store
   always_comb begin
      if (state_ff == S_CLEAR) begin
         ram_we = 1'b1;
         ram_wa = clr_ff;
         ram_wd = 16'h0000;
      end else begin
         ram_we = wen;
         ram_wa = widx[AW-1:0];
         ram_wd = req_value;
      end
   end

   // pack bytes four to a group and hand groups to the output register
   always_comb begin
      acc_in = acc_ff;
      acnt_in = acnt_ff;
      rb_in = rb_ff;
      rn_in = rn_ff;
      rl_in = rl_ff;
      rv_in = rv_ff && !rsp_ready;
      if (emit) begin
         if (acnt_ff == 2'd3 || elast) begin
            for (int j = 0; j < 4; j++) begin
               if (j < 32'(acnt_ff)) begin
                  rb_in[j] = acc_ff[j[1:0]];
               end else if (j == 32'(acnt_ff)) begin
                  rb_in[j] = ebyte;
               end else begin
                  rb_in[j] = 8'h00;
               end
            end
            rn_in   = {1'b0, acnt_ff} + 3'd1;
            rl_in   = elast;
            rv_in   = 1'b1;
            acnt_in = 2'd0;
         end else begin
            acc_in[acnt_ff] = ebyte;
            acnt_in         = acnt_ff + 2'd1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         tend_ff  <= 12'd4093;
         std_ff   <= 1'b1;
         wa_ff    <= 1'b0;
         wp_ff    <= 16'd0;
         wr_ff    <= 16'd0;
         echo_ff  <= 48'd0;
         acnt_ff  <= 2'd0;
         rv_ff    <= 1'b0;
         hidx_ff  <= 3'd0;
         hlen_ff  <= 3'd0;
         words_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         tend_ff  <= tend_in;
         std_ff   <= std_in;
         wa_ff    <= wa_in;
         wp_ff    <= wp_in;
         wr_ff    <= wr_in;
         echo_ff  <= echo_in;
         acnt_ff  <= acnt_in;
         rv_ff    <= rv_in;
         hidx_ff  <= hidx_in;
         hlen_ff  <= hlen_in;
         words_ff <= words_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hdr_ff   <= hdr_in;
      raddr_ff <= raddr_in;
      oor_ff   <= oor_in;
      crc_ff   <= crc_in;
      acc_ff   <= acc_in;
      rb_ff    <= rb_in;
      rn_ff    <= rn_in;
      rl_ff    <= rl_in;
   end

   assign rsp_valid  = rv_ff;
   assign rsp_byte0  = rb_ff[0];
   assign rsp_byte1  = rb_ff[1];
   assign rsp_byte2  = rb_ff[2];
   assign rsp_byte3  = rb_ff[3];
   assign rsp_nbytes = rn_ff;
   assign rsp_last   = rl_ff;

   // no request is taken during the clearing pass
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_ready)
      else $error("request accepted during table clear");

   // a pending non-final group means the frame is still being built
   a_frame_open: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rl_ff |-> state_ff != S_IDLE && state_ff != S_CLEAR)
      else $error("frame closed with a group still open");

   // partial group only while emitting
   a_acc_idle: assert property (@(posedge clock) disable iff (reset)
      acnt_ff != 2'd0 |-> state_ff != S_IDLE && state_ff != S_CLEAR)
      else $error("packed bytes left over in idle");

   // group size is always one to four
   a_nbytes: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> rn_ff != 3'd0 && rn_ff <= 3'd4)
      else $error("bad group size");

endmodule
